// ----- rtl/dqsb_pkg.sv -----
// Types and constants shared by the dual-queue shared-buffer block.
package dqsb_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int COUNT_W = 5;

  localparam logic [1:0] KIND_ENQ        = 2'd0;
  localparam logic [1:0] KIND_DEQ_FIRST  = 2'd1;
  localparam logic [1:0] KIND_DEQ_SECOND = 2'd2;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] head_first;
    logic                     first_valid;
    logic signed [DATA_W-1:0] head_second;
    logic                     second_valid;
    logic [COUNT_W-1:0]       count_first;
    logic [COUNT_W-1:0]       count_second;
  } out_t;

  // Per-cell command: load the incoming value, take the upper neighbor's
  // entry (queue one shifting down), or take the lower neighbor's entry
  // (queue two shifting up). All zero holds.
  typedef struct packed {
    logic load;
    logic take_upper;
    logic take_lower;
  } cell_ctl_t;

endpackage

// ----- rtl/dqsb_cell.sv -----
// One buffer entry of the shared queue array, with neighbor links.
module dqsb_cell
  import dqsb_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] value,
  input  logic [DATA_W-1:0] upper_in,
  input  logic [DATA_W-1:0] lower_in,
  output logic [DATA_W-1:0] data_o,
  output logic [DATA_W-1:0] data_nxt_o
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    if (ctl.load) begin
      data_nxt = value;
    end else if (ctl.take_upper) begin
      data_nxt = upper_in;
    end else if (ctl.take_lower) begin
      data_nxt = lower_in;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o     = data_r;
  assign data_nxt_o = data_nxt;

endmodule

// ----- rtl/dual_queue_shared_buffer_top.sv -----
// Top level: two FIFO queues sharing one row of DEPTH entry cells.
//
// Two queues live in one buffer of DEPTH entries: queue one fills from
// entry 0, queue two from entry DEPTH-1, and each head sits at its end.
// An enqueue goes to the shorter queue (queue one on a tie) and fails when
// the buffer is full; a dequeue removes a head and every entry of that
// queue moves one cell toward its end in the same clock. Each cell holds
// one entry and loads from the input or a neighbor, so one operation is
// taken per clock; the result (status, both heads, both counts) appears
// from the output register in the cycle after acceptance, and a new item is
// accepted while that register is free or being drained. Entries are not
// cleared by reset; a head is reported as zero while its queue is empty.
module dual_queue_shared_buffer_top
  import dqsb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic [CNT_W-1:0] fill_first_r, fill_first_nxt;
  logic [CNT_W-1:0] fill_second_r, fill_second_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic             in_accept;
  logic             is_full;
  logic             go_first;
  logic             do_enq_first, do_enq_second;
  logic             do_deq_first, do_deq_second;
  logic             res_ok;

  cell_ctl_t         cell_ctl [DEPTH];
  logic [DATA_W-1:0] cell_q   [DEPTH];
  logic [DATA_W-1:0] cell_nxt [DEPTH];

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign is_full  = ({1'b0, fill_first_r} + {1'b0, fill_second_r}) >= (CNT_W+1)'(DEPTH);
  assign go_first = fill_first_r <= fill_second_r;

  always_comb begin
    do_enq_first  = 1'b0;
    do_enq_second = 1'b0;
    do_deq_first  = 1'b0;
    do_deq_second = 1'b0;
    case (in_data.kind)
      KIND_ENQ: begin
        do_enq_first  = in_accept && !is_full && go_first;
        do_enq_second = in_accept && !is_full && !go_first;
      end
      KIND_DEQ_FIRST: begin
        do_deq_first = in_accept && (fill_first_r != '0);
      end
      KIND_DEQ_SECOND: begin
        do_deq_second = in_accept && (fill_second_r != '0);
      end
      default: begin
      end
    endcase
  end

  assign res_ok = do_enq_first || do_enq_second || do_deq_first || do_deq_second;

  always_comb begin
    fill_first_nxt  = fill_first_r;
    fill_second_nxt = fill_second_r;
    if (do_enq_first) begin
      fill_first_nxt = fill_first_r + 1'b1;
    end else if (do_deq_first) begin
      fill_first_nxt = fill_first_r - 1'b1;
    end
    if (do_enq_second) begin
      fill_second_nxt = fill_second_r + 1'b1;
    end else if (do_deq_second) begin
      fill_second_nxt = fill_second_r - 1'b1;
    end
  end

  // Row of cells; each decodes its own command from the fill levels.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W:0] CELL_IDX = (CNT_W+1)'(i);
    logic [DATA_W-1:0] upper_link;
    logic [DATA_W-1:0] lower_link;

    always_comb begin
      cell_ctl[i].load = (do_enq_first && (CELL_IDX == {1'b0, fill_first_r}))
                      || (do_enq_second
                          && ((CELL_IDX + {1'b0, fill_second_r}) == (CNT_W+1)'(DEPTH - 1)));
      cell_ctl[i].take_upper = do_deq_first && ((CELL_IDX + 1'b1) < {1'b0, fill_first_r});
      cell_ctl[i].take_lower = do_deq_second
                            && ((CELL_IDX + {1'b0, fill_second_r}) > (CNT_W+1)'(DEPTH));
    end

    if (i == DEPTH - 1) begin : g_top_edge
      assign upper_link = '0;
    end else begin : g_top_link
      assign upper_link = cell_q[i+1];
    end
    if (i == 0) begin : g_bot_edge
      assign lower_link = '0;
    end else begin : g_bot_link
      assign lower_link = cell_q[i-1];
    end

    dqsb_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .value      (in_data.value),
      .upper_in   (upper_link),
      .lower_in   (lower_link),
      .data_o     (cell_q[i]),
      .data_nxt_o (cell_nxt[i])
    );
  end

  always_comb begin
    out_data_nxt              = out_data_r;
    out_valid_nxt             = out_valid_r && out_stall;
    if (in_accept) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.ok           = res_ok;
      out_data_nxt.first_valid  = fill_first_nxt != '0;
      out_data_nxt.head_first   = (fill_first_nxt != '0) ? cell_nxt[0] : '0;
      out_data_nxt.second_valid = fill_second_nxt != '0;
      out_data_nxt.head_second  = (fill_second_nxt != '0) ? cell_nxt[DEPTH-1] : '0;
      out_data_nxt.count_first  = COUNT_W'(fill_first_nxt);
      out_data_nxt.count_second = COUNT_W'(fill_second_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_first_r  <= '0;
      fill_second_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      fill_first_r  <= fill_first_nxt;
      fill_second_r <= fill_second_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, fill_first_r} + {1'b0, fill_second_r}) <= (CNT_W+1)'(DEPTH))
    else $error("queues hold more than the buffer depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !res_ok) |=> ($stable(fill_first_r) && $stable(fill_second_r)))
    else $error("failed operation changed a fill level");

  a_one_queue_moves: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({do_enq_first, do_enq_second, do_deq_first, do_deq_second}))
    else $error("more than one queue operation in a cycle");

endmodule

// ----- bench/tb_dual_queue_shared_buffer_top.sv -----
// Self-checking bench for the dual-queue shared-buffer top: directed table, then random traffic.
module tb_dual_queue_shared_buffer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dqsb_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam int RANDOM_OPS = 450;
  localparam int CALM_TAIL  = 60;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;

  dual_queue_shared_buffer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  typedef struct {
    in_t  op;
    bit   pinned;
    out_t want;
  } dir_row_t;

  // Bench copy of the shared array and the two fill levels
  logic [DATA_W-1:0] shadow_mem [DEPTH];
  int unsigned fill_lo = 0;
  int unsigned fill_hi = 0;

  out_t        status_due[$];     // expected status words, oldest first
  bit          pin_flag[$];       // per driven op: typed-in expectation present
  out_t        pin_status[$];
  int unsigned n_errors  = 0;
  int unsigned n_checked = 0;
  int unsigned idle_odds = 0;
  bit          calm      = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Applies one queue operation to the shadow state and returns the status word.
  function automatic out_t apply_queue_op(input in_t op);
    out_t res;
    bit   ok;
    ok = 1'b0;
    case (op.kind)
      KIND_ENQ: begin
        if (fill_lo + fill_hi < DEPTH) begin
          ok = 1'b1;
          if (fill_lo <= fill_hi) begin
            shadow_mem[fill_lo] = op.value;
            fill_lo++;
          end else begin
            shadow_mem[DEPTH - 1 - fill_hi] = op.value;
            fill_hi++;
          end
        end
      end
      KIND_DEQ_FIRST: begin
        if (fill_lo != 0) begin
          ok = 1'b1;
          for (int i = 0; i < DEPTH - 1; i++)
            if (i + 1 < fill_lo) shadow_mem[i] = shadow_mem[i + 1];
          fill_lo--;
        end
      end
      KIND_DEQ_SECOND: begin
        if (fill_hi != 0) begin
          ok = 1'b1;
          for (int i = DEPTH - 1; i > 0; i--)
            if (i > DEPTH - int'(fill_hi)) shadow_mem[i] = shadow_mem[i - 1];
          fill_hi--;
        end
      end
      default: ok = 1'b0;
    endcase
    res.ok           = ok;
    res.first_valid  = (fill_lo != 0);
    res.head_first   = (fill_lo != 0) ? shadow_mem[0] : '0;
    res.second_valid = (fill_hi != 0);
    res.head_second  = (fill_hi != 0) ? shadow_mem[DEPTH - 1] : '0;
    res.count_first  = fill_lo[COUNT_W-1:0];
    res.count_second = fill_hi[COUNT_W-1:0];
    return res;
  endfunction

  function automatic out_t status_of(input bit ok, input logic [DATA_W-1:0] hf,
                                     input logic [DATA_W-1:0] hs, input int cf, input int cs);
    out_t s;
    s.ok           = ok;
    s.head_first   = hf;
    s.first_valid  = (cf != 0);
    s.head_second  = hs;
    s.second_valid = (cs != 0);
    s.count_first  = cf[COUNT_W-1:0];
    s.count_second = cs[COUNT_W-1:0];
    return s;
  endfunction

  function automatic in_t op_of(input logic [1:0] kind, input logic [DATA_W-1:0] value);
    in_t op;
    op.kind  = kind;
    op.value = value;
    return op;
  endfunction

  task automatic log_mismatch(input string what, input logic [DATA_W-1:0] got,
                              input logic [DATA_W-1:0] want);
    n_errors++;
    $display("[%0t] result %0d: %s got %h want %h", $realtime, n_checked, what, got, want);
  endtask

  task automatic check_status(input out_t got, input out_t want);
    if (got.ok !== want.ok) log_mismatch("ok", DATA_W'(got.ok), DATA_W'(want.ok));
    if (got.head_first !== want.head_first)
      log_mismatch("head_first", got.head_first, want.head_first);
    if (got.first_valid !== want.first_valid)
      log_mismatch("first_valid", DATA_W'(got.first_valid), DATA_W'(want.first_valid));
    if (got.head_second !== want.head_second)
      log_mismatch("head_second", got.head_second, want.head_second);
    if (got.second_valid !== want.second_valid)
      log_mismatch("second_valid", DATA_W'(got.second_valid), DATA_W'(want.second_valid));
    if (got.count_first !== want.count_first)
      log_mismatch("count_first", DATA_W'(got.count_first), DATA_W'(want.count_first));
    if (got.count_second !== want.count_second)
      log_mismatch("count_second", DATA_W'(got.count_second), DATA_W'(want.count_second));
  endtask

  // Input transaction: predict first, so a same-edge result would still find its expectation
  always @(posedge clk) begin
    out_t calc;
    out_t want;
    bit   pinned;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        calc   = apply_queue_op(in_data);
        pinned = pin_flag.pop_front();
        want   = pin_status.pop_front();
        status_due.push_back(pinned ? want : calc);
      end
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          log_mismatch("result with nothing pending", DATA_W'(out_data.count_first), '0);
        end else begin
          want = status_due.pop_front();
          check_status(out_data, want);
        end
        n_checked++;
      end
    end
  end

  task automatic drive_op(input in_t op, input bit pinned, input out_t want);
    if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    pin_flag.push_back(pinned);
    pin_status.push_back(want);
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Result-side backpressure: stretches of differing density, none in the tail
  initial begin
    int unsigned odds;
    int unsigned span;
    forever begin
      case ($urandom_range(0, 2))
        0:       odds = 0;
        1:       odds = 3;
        default: odds = 8;
      endcase
      span = $urandom_range(20, 60);
      repeat (span) begin
        @(posedge clk);
        if (!calm && odds != 0 && $urandom_range(1, odds) == 1) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 7)) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    dir_row_t    rows[$];
    dir_row_t    r;
    out_t        none;
    logic [1:0]  kind;
    logic [DATA_W-1:0] value;
    int unsigned push_pct;
    out_t        empty_st;
    out_t        full_st;

    none     = '0;
    empty_st = status_of(1'b0, '0, '0, 0, 0);
    full_st  = status_of(1'b0, VAL_MAX, VAL_MIN, DEPTH / 2, DEPTH / 2);
    foreach (shadow_mem[i]) shadow_mem[i] = '0;

    // Empty-queue dequeues and the unused code all fail with nothing to show
    rows.push_back('{op_of(KIND_DEQ_FIRST, '0), 1'b1, empty_st});
    rows.push_back('{op_of(KIND_DEQ_SECOND, '1), 1'b1, empty_st});
    rows.push_back('{op_of(KIND_UNUSED, '1), 1'b1, empty_st});
    rows.push_back('{op_of(KIND_ENQ, VAL_MAX), 1'b1, status_of(1'b1, VAL_MAX, '0, 1, 0)});
    rows.push_back('{op_of(KIND_ENQ, VAL_MIN), 1'b1, status_of(1'b1, VAL_MAX, VAL_MIN, 1, 1)});
    for (int i = 0; i < DEPTH - 2; i++) begin
      value = (i % 2) ? 32'hAAAA_AAAA - i : 32'h5555_5555 + i;
      rows.push_back('{op_of(KIND_ENQ, value), 1'b0, none});
    end
    // Buffer full: enqueue refused, state held
    rows.push_back('{op_of(KIND_ENQ, 32'h0000_1234), 1'b1, full_st});
    rows.push_back('{op_of(KIND_UNUSED, '0), 1'b1, full_st});
    rows.push_back('{op_of(KIND_DEQ_FIRST, '1), 1'b0, none});
    rows.push_back('{op_of(KIND_DEQ_SECOND, '0), 1'b0, none});
    rows.push_back('{op_of(KIND_DEQ_FIRST, VAL_MIN), 1'b0, none});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_odds = 4;
    foreach (rows[i]) begin
      r = rows[i];
      drive_op(r.op, r.pinned, r.want);
    end

    // Random part in epochs that lean toward filling, draining, or neither
    push_pct = 50;
    for (int k = 0; k < RANDOM_OPS; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 75;
          1:       push_pct = 25;
          default: push_pct = 50;
        endcase
        case ($urandom_range(0, 2))
          0:       idle_odds = 0;
          1:       idle_odds = 3;
          default: idle_odds = 8;
        endcase
      end
      if (k >= RANDOM_OPS - CALM_TAIL) calm = 1'b1;
      if ($urandom_range(0, 99) < 3)
        kind = KIND_UNUSED;
      else if ($urandom_range(0, 99) < push_pct)
        kind = KIND_ENQ;
      else
        kind = $urandom_range(0, 1) ? KIND_DEQ_FIRST : KIND_DEQ_SECOND;
      case ($urandom_range(0, 7))
        0:       value = VAL_MIN;
        1:       value = VAL_MAX;
        2:       value = '0;
        3:       value = '1;
        default: value = $urandom;
      endcase
      drive_op(op_of(kind, value), 1'b0, none);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (n_errors == 0 && status_due.size() == 0) begin
      $display("** dual_queue_shared_buffer_top: PASSED **");
    end else begin
      $display("** dual_queue_shared_buffer_top: FAILED **");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #400_000;
    $display("** dual_queue_shared_buffer_top: FAILED **");
    $finish;
  end

endmodule
